// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL, included by matrix3_inverse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/mi3_pkg.sv =====
package mi3_pkg;

  // Element format.
  localparam int EW = 32;
  localparam int FB = 16;

  // Derived widths: cofactor, determinant, numerator magnitude, remainder, quotient.
  localparam int CW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 3;
  localparam int NMW = CW + 2 * FB;
  localparam int RW  = DW + EW + 2;
  localparam int QW  = EW + 1;

  // Queue between the front and back parts.
  localparam int QD   = 8;
  localparam int QAW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);

  // Front pipeline depth and divider lane latency.
  localparam int FSTG = 4;
  localparam int LSTG = EW + 3;

  // Cofactor n = m[A]*m[B] - m[C]*m[D], row-major element numbering.
  localparam int COF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic signed [EW-1:0] m00;
    logic signed [EW-1:0] m01;
    logic signed [EW-1:0] m02;
    logic signed [EW-1:0] m10;
    logic signed [EW-1:0] m11;
    logic signed [EW-1:0] m12;
    logic signed [EW-1:0] m20;
    logic signed [EW-1:0] m21;
    logic signed [EW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [EW-1:0] inv00;
    logic signed [EW-1:0] inv01;
    logic signed [EW-1:0] inv02;
    logic signed [EW-1:0] inv10;
    logic signed [EW-1:0] inv11;
    logic signed [EW-1:0] inv12;
    logic signed [EW-1:0] inv20;
    logic signed [EW-1:0] inv21;
    logic signed [EW-1:0] inv22;
    logic                 singular;
  } out_t;

  // One queued request: the nine adjugate cofactors and the determinant.
  typedef struct packed {
    logic [8:0][CW-1:0] cof;
    logic [DW-1:0]      det;
  } ent_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic           nempty;
    logic [QCW-1:0] cnt;
  } qstat_t;

endpackage

// ===== src/matrix3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, signed Q16.16 elements. One matrix is
// accepted per cycle when the input is not stalled, and one result leaves per
// cycle when the output is not stalled. From acceptance to result, four stages
// compute the cofactors and the determinant, the request passes through an
// eight-entry queue, and nine pipelined restoring dividers take 35 stages
// (magnitudes, a saturation check, then one quotient bit per stage) before the
// output register. Quotients are truncated toward zero and saturated; a zero
// determinant raises singular and zeroes all nine elements. The input stalls
// while the queue and the front stages together hold eight requests.
module matrix3_inverse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mi3_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mi3_pkg::out_t out_data
);
  import mi3_pkg::*;
  `include "assert_macros.svh"

  qstat_t          qs;
  ent_t            wr_ent;
  ent_t            rd_ent;
  logic            push;
  logic            pop;
  logic            sing_out;
  logic [9*EW-1:0] inv_bits;

  mi3_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qs       (qs),
    .push     (push),
    .ent      (wr_ent)
  );

  mi3_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wr_ent),
    .pop   (pop),
    .rdata (rd_ent),
    .qs    (qs)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent       (rd_ent),
    .qs        (qs),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // All nine inverse elements of the result, above the singular flag.
  assign sing_out = out_valid && out_data.singular;
  assign inv_bits = out_data[9*EW:1];

  // The queue never overflows or underflows.
  `ASSERT_NEVER(a_q_over, clk, rst_n, qs.cnt > QCW'(QD), "queue count above depth")
  `ASSERT_NEVER(a_q_under, clk, rst_n, pop && !qs.nempty, "pop from an empty queue")
  // A singular result carries only zero elements.
  `ASSERT_CLK(a_sing_zero, clk, rst_n, sing_out |-> (inv_bits == '0), "singular result not zero")

endmodule

// ===== src/mi3_front.sv =====
module mi3_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mi3_pkg::in_t   in_data,
  input  mi3_pkg::qstat_t qs,
  output logic           push,
  output mi3_pkg::ent_t  ent
);
  import mi3_pkg::*;

  logic signed [EW-1:0]   m [9];
  logic [FSTG-1:0]        v_r;
  logic signed [2*EW-1:0] p1_r [9];
  logic signed [2*EW-1:0] p2_r [9];
  logic signed [EW-1:0]   r1_r [3];
  logic signed [EW-1:0]   r2_r [3];
  logic signed [CW-1:0]   c2_r [9];
  logic signed [CW-1:0]   c3_r [9];
  logic signed [CW-1:0]   plo_r [3];
  logic signed [CW-1:0]   phi_r [3];
  logic signed [DW-1:0]   det_r;
  logic signed [CW-1:0]   c4_r [9];
  logic [QCW:0]           busy;
  logic                   acc;

  assign m[0] = in_data.m00;
  assign m[1] = in_data.m01;
  assign m[2] = in_data.m02;
  assign m[3] = in_data.m10;
  assign m[4] = in_data.m11;
  assign m[5] = in_data.m12;
  assign m[6] = in_data.m20;
  assign m[7] = in_data.m21;
  assign m[8] = in_data.m22;

  // Accept only when the queue has room for every request already in flight.
  always_comb begin
    busy = {1'b0, qs.cnt};
    for (int i = 0; i < FSTG; i++) begin
      busy = busy + (QCW + 1)'(v_r[i]);
    end
  end
  assign in_stall = (busy >= (QCW + 1)'(QD));
  assign acc      = in_valid && !in_stall;

  // Valid bits of the front pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FSTG-2:0], acc};
    end
  end

  // Stage 1: the eighteen element products. Stage 2: the cofactors.
  for (genvar i = 0; i < 9; i++) begin : g_cof
    always_ff @(posedge clk) begin
      p1_r[i] <= m[COF_A[i]] * m[COF_B[i]];
      p2_r[i] <= m[COF_C[i]] * m[COF_D[i]];
      c2_r[i] <= CW'(p1_r[i]) - CW'(p2_r[i]);
      c3_r[i] <= c2_r[i];
      c4_r[i] <= c3_r[i];
    end
  end

  // Stage 3: first-row element times its cofactor, split into two halves.
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      r1_r[j]  <= m[j];
      r2_r[j]  <= r1_r[j];
      plo_r[j] <= r2_r[j] * $signed({1'b0, c2_r[3*j][EW-1:0]});
      phi_r[j] <= r2_r[j] * $signed(c2_r[3*j][CW-1:EW]);
    end
  end

  // Stage 4: the determinant as the sum of the six partial products.
  always_ff @(posedge clk) begin
    det_r <= (DW'(phi_r[0]) <<< EW) + DW'(plo_r[0])
           + (DW'(phi_r[1]) <<< EW) + DW'(plo_r[1])
           + (DW'(phi_r[2]) <<< EW) + DW'(plo_r[2]);
  end

  assign push = v_r[FSTG-1];
  always_comb begin
    ent.det = det_r;
    for (int i = 0; i < 9; i++) begin
      ent.cof[i] = c4_r[i];
    end
  end

endmodule

// ===== src/mi3_queue.sv =====
module mi3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mi3_pkg::ent_t   wdata,
  input  logic            pop,
  output mi3_pkg::ent_t   rdata,
  output mi3_pkg::qstat_t qs
);
  import mi3_pkg::*;

  ent_t           mem_r [QD];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QCW-1:0] cnt_r;

  // Pointer and count bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata     = mem_r[rp_r];
  assign qs.cnt    = cnt_r;
  assign qs.nempty = (cnt_r != '0);

endmodule

// ===== src/mi3_div.sv =====
module mi3_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mi3_pkg::CW-1:0]      num,
  input  logic [mi3_pkg::DW-1:0]      den,
  output logic [mi3_pkg::EW-1:0]      quo
);
  import mi3_pkg::*;

  localparam logic [QW-1:0] LIM  = QW'(1) << (EW - 1);
  localparam logic [EW-1:0] MAXP = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] MINN = {1'b1, {(EW-1){1'b0}}};

  logic [CW-1:0] nm_r;
  logic [DW-1:0] dm_r;
  logic          na_r;
  logic [RW-1:0] rem_r [EW+2];
  logic [DW-1:0] d_r   [EW+2];
  logic [QW-1:0] q_r   [EW+2];
  logic          neg_r [EW+2];
  logic          ovf_r [EW+2];
  logic [RW-1:0] nsh;
  logic [RW-1:0] dsh;

  // Stage A: magnitudes and the sign of the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      nm_r <= num[CW-1] ? (CW'(0) - num) : num;
      dm_r <= den[DW-1] ? (DW'(0) - den) : den;
      na_r <= num[CW-1] ^ den[DW-1];
    end
  end

  // Stage B: a quotient that needs more than QW bits saturates.
  assign nsh = RW'({nm_r, {(2*FB){1'b0}}});
  assign dsh = RW'(dm_r) << QW;
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nsh;
      d_r[0]   <= dm_r;
      q_r[0]   <= '0;
      neg_r[0] <= na_r;
      ovf_r[0] <= (nsh >= dsh);
    end
  end

  // Restoring division, one quotient bit per stage from the top.
  for (genvar i = 0; i <= EW; i++) begin : g_stg
    logic [RW-1:0] trial;
    assign trial = RW'(d_r[i]) << (EW - i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[i] >= trial) begin
          rem_r[i+1] <= rem_r[i] - trial;
          q_r[i+1]   <= q_r[i] | (QW'(1) << (EW - i));
        end else begin
          rem_r[i+1] <= rem_r[i];
          q_r[i+1]   <= q_r[i];
        end
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  // Apply the sign and saturate to the element range.
  always_comb begin
    if (neg_r[EW+1]) begin
      if (ovf_r[EW+1] || q_r[EW+1] > LIM) begin
        quo = MINN;
      end else begin
        quo = EW'(0) - q_r[EW+1][EW-1:0];
      end
    end else begin
      if (ovf_r[EW+1] || q_r[EW+1] >= LIM) begin
        quo = MAXP;
      end else begin
        quo = q_r[EW+1][EW-1:0];
      end
    end
  end

endmodule

// ===== src/mi3_back.sv =====
module mi3_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mi3_pkg::ent_t   ent,
  input  mi3_pkg::qstat_t qs,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output mi3_pkg::out_t   out_data
);
  import mi3_pkg::*;

  logic [LSTG-1:0] v_r;
  logic [LSTG-1:0] s_r;
  logic            en;
  logic [EW-1:0]   quo [9];
  logic            ov_r;
  out_t            od_r;

  // The whole back pipeline moves unless a finished result is held.
  assign en  = !(ov_r && out_stall);
  assign pop = en && qs.nempty;

  // Valid and singular flags travel beside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[LSTG-2:0], qs.nempty};
      ov_r <= v_r[LSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= {s_r[LSTG-2:0], (ent.det == '0)};
    end
  end

  // Nine divider lanes, one per inverse element.
  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_div u_div (
      .clk (clk),
      .en  (en),
      .num (ent.cof[i]),
      .den (ent.det),
      .quo (quo[i])
    );
  end

  // Output register; a singular matrix gives all zero elements.
  always_ff @(posedge clk) begin
    if (en) begin
      od_r.singular <= s_r[LSTG-1];
      od_r.inv00    <= s_r[LSTG-1] ? '0 : quo[0];
      od_r.inv01    <= s_r[LSTG-1] ? '0 : quo[1];
      od_r.inv02    <= s_r[LSTG-1] ? '0 : quo[2];
      od_r.inv10    <= s_r[LSTG-1] ? '0 : quo[3];
      od_r.inv11    <= s_r[LSTG-1] ? '0 : quo[4];
      od_r.inv12    <= s_r[LSTG-1] ? '0 : quo[5];
      od_r.inv20    <= s_r[LSTG-1] ? '0 : quo[6];
      od_r.inv21    <= s_r[LSTG-1] ? '0 : quo[7];
      od_r.inv22    <= s_r[LSTG-1] ? '0 : quo[8];
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== sim/tb_matrix3_inverse.sv =====
`timescale 1ns / 1ps

module tb_matrix3_inverse;
  import mi3_pkg::*;

  // Scoreboard: predicts each inverse and checks results in order.
  class inverse_scoreboard;
    out_t pending_inv[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    // Predict the inverse of one accepted matrix.
    function void note_matrix(in_t m);
      logic signed [255:0] e[9];
      logic signed [255:0] adj[9];
      logic signed [255:0] det, num, quo;
      logic signed [255:0] hi, lo;
      logic signed [EW-1:0] res[9];
      out_t r;
      e = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
      hi = (256'sd1 <<< (EW - 1)) - 1;
      lo = -(256'sd1 <<< (EW - 1));
      for (int i = 0; i < 9; i++) begin
        adj[i] = e[COF_A[i]] * e[COF_B[i]] - e[COF_C[i]] * e[COF_D[i]];
      end
      det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      for (int i = 0; i < 9; i++) begin
        if (det == 0) begin
          res[i] = '0;
        end else begin
          num = adj[i] <<< (2 * FB);
          // Signed division truncates toward zero.
          quo = num / det;
          if (quo > hi) quo = hi;
          if (quo < lo) quo = lo;
          res[i] = quo[EW-1:0];
        end
      end
      r.inv00 = res[0]; r.inv01 = res[1]; r.inv02 = res[2];
      r.inv10 = res[3]; r.inv11 = res[4]; r.inv12 = res[5];
      r.inv20 = res[6]; r.inv21 = res[7]; r.inv22 = res[8];
      r.singular = (det == 0);
      pending_inv.push_back(r);
    endfunction

    // Compare one result with the oldest prediction.
    function void check_result(out_t got);
      out_t x;
      if (pending_inv.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      x = pending_inv.pop_front();
      if (got.inv00 !== x.inv00) report($sformatf("inv00 %h exp %h", got.inv00, x.inv00));
      if (got.inv01 !== x.inv01) report($sformatf("inv01 %h exp %h", got.inv01, x.inv01));
      if (got.inv02 !== x.inv02) report($sformatf("inv02 %h exp %h", got.inv02, x.inv02));
      if (got.inv10 !== x.inv10) report($sformatf("inv10 %h exp %h", got.inv10, x.inv10));
      if (got.inv11 !== x.inv11) report($sformatf("inv11 %h exp %h", got.inv11, x.inv11));
      if (got.inv12 !== x.inv12) report($sformatf("inv12 %h exp %h", got.inv12, x.inv12));
      if (got.inv20 !== x.inv20) report($sformatf("inv20 %h exp %h", got.inv20, x.inv20));
      if (got.inv21 !== x.inv21) report($sformatf("inv21 %h exp %h", got.inv21, x.inv21));
      if (got.inv22 !== x.inv22) report($sformatf("inv22 %h exp %h", got.inv22, x.inv22));
      if (got.singular !== x.singular)
        report($sformatf("singular %b exp %b", got.singular, x.singular));
    endfunction
  endclass

  localparam int ONE      = 1 << FB;
  localparam int N_RANDOM = 2000;
  localparam int WD_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  logic calm_in = 0;
  logic calm_out = 0;
  int   idle_cycles = 0;
  inverse_scoreboard sb = new();

  matrix3_inverse i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Monitor both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_matrix(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_matrix3_inverse NOT OK");
      $finish;
    end
  end

  // Receiver stalls about 22 percent of the time except in calm stretches.
  always @(negedge clk) begin
    out_stall = !calm_out && ($urandom_range(99) < 22);
  end

  // Send one request, idling at random beforehand.
  task automatic send_matrix(in_t m);
    while (!calm_in && $urandom_range(99) < 22) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data  = m;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random element: full range, small Q16.16 values, tiny raw values from -1 to 2, or an extreme.
  function automatic logic [31:0] rand_elem();
    int k;
    k = $urandom_range(9);
    if (k < 3) return $urandom();
    if (k < 8) return $signed($urandom_range(8 * ONE)) - 4 * ONE;
    if (k == 8) return $urandom_range(3) - 1;
    return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic in_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    in_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  initial begin
    in_t m;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // Directed: identity, zero, extremes, saturation and singular cases.
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix('0);
    send_matrix(diag(-ONE, 2 * ONE, ONE / 2));
    send_matrix(diag(1, 1, 1));
    send_matrix(diag(-1, 1, 1));
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h8000_0000, 1, 1));
    send_matrix({9{32'h7fff_ffff}});
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'hffff_ffff}});
    m = diag(ONE, ONE, ONE);
    m.m12 = 3 * ONE; m.m02 = -5 * ONE; m.m10 = 7 * ONE;
    send_matrix(m);
    m = diag(2 * ONE, 3 * ONE, 4 * ONE);
    m.m01 = ONE; m.m21 = -ONE;
    send_matrix(m);
    // Two equal rows make the matrix singular.
    m = {$urandom(), $urandom(), $urandom(), 96'h0, $urandom(), $urandom(), $urandom()};
    m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02;
    send_matrix(m);
    m = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_matrix(m);

    // Random part with a calm stretch and a pause until drained.
    for (int n = 0; n < N_RANDOM; n++) begin
      calm_in  = (n >= 800 && n < 1100);
      calm_out = calm_in;
      if (n == 1200) begin
        in_valid = 0;
        while (sb.pending_inv.size() != 0) @(negedge clk);
      end
      for (int i = 0; i < 9; i++) m[i*32 +: 32] = rand_elem();
      if ($urandom_range(9) == 0) begin
        // Copy a column to force a zero determinant.
        m.m01 = m.m00; m.m11 = m.m10; m.m21 = m.m20;
      end
      send_matrix(m);
    end
    in_valid = 0;
    calm_out = 0;

    while (sb.pending_inv.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_matrix3_inverse OK");
    end else begin
      $display("tb_matrix3_inverse NOT OK");
    end
    $finish;
  end
endmodule
